// ===== rtl/sliding_window_log_rate_limiter_defines.svh =====
// ----------------------------------------------------------------------------
// sliding window log rate limiter: assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_LOG_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_LOG_RATE_LIMITER_DEFINES_SVH

// same-cycle implication
`define SWLRL_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("swlrl port check failed");

// next-cycle implication
`define SWLRL_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("swlrl port check failed");

`endif

// ===== rtl/swlrl_pkg.sv =====
// ----------------------------------------------------------------------------
// swlrl_pkg
// field widths, register map and controller/datapath handshake types
// ----------------------------------------------------------------------------
package swlrl_pkg;

   localparam int STAMP_W    = 48;
   localparam int SLOT_IN_W  = 6;
   localparam int WINDOW_W   = 32;
   localparam int LIMIT_W    = 5;
   localparam int LIVE_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_MS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_REQUESTS = 1'd1;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd60000;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd10;

   // controller to datapath
   typedef struct packed {
      logic clear;   // zero one slot of the ring table
      logic accept;  // capture request word
      logic load;    // take ring head and count from table
      logic pop;     // drop the head stamp
      logic decide;  // append / refuse, write back, load result
   } swlrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_ok;
      logic clear_done;
      logic cnt_zero;
      logic expired;
   } swlrl_sts_type;

endpackage

// ===== rtl/swlrl_if.sv =====
// ----------------------------------------------------------------------------
// swlrl request and response channels
// valid/ready channels carrying one request or one result word
// ----------------------------------------------------------------------------
interface swlrl_req_if import swlrl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SLOT_IN_W-1:0] user_slot;
   logic [STAMP_W-1:0]   now_ms;

   modport source (output valid, output user_slot, output now_ms, input ready);
   modport sink   (input valid, input user_slot, input now_ms, output ready);
endinterface

interface swlrl_rsp_if import swlrl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              allowed;
   logic [LIVE_W-1:0] live_count;

   modport source (output valid, output allowed, output live_count, input ready);
   modport sink   (input valid, input allowed, input live_count, output ready);
endinterface

// ===== rtl/swlrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// swlrl_ctrl
// sequencer: table clear, ring load, expiry loop, decision and result hold
// ----------------------------------------------------------------------------
module swlrl_ctrl import swlrl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  swlrl_sts_type sts,
   output swlrl_cmd_type cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_EXPIRE = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.slot_ok ? S_LOAD : S_DECIDE;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_EXPIRE;
         end
         S_EXPIRE: begin
            if (sts.cnt_zero || !sts.expired) begin
               state_in = S_DECIDE;
            end else begin
               cmd.pop = 1'b1;
            end
         end
         S_DECIDE: begin
            // hold here while the previous result is still waiting
            if (out_free) begin
               cmd.decide = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.decide) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/swlrl_dp.sv =====
// ----------------------------------------------------------------------------
// swlrl_dp
// stamp memory, ring table, window compare, limit check and result word
// ----------------------------------------------------------------------------
module swlrl_dp import swlrl_pkg::*; #(
   parameter int NUM_SLOTS = 64,
   parameter int LOG_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swlrl_cmd_type         cmd,
   output swlrl_sts_type         sts,
   input  logic [SLOT_IN_W-1:0]  req_user_slot,
   input  logic [STAMP_W-1:0]    req_now_ms,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_allowed,
   output logic [LIVE_W-1:0]     rsp_live_count
);

   localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int HEAD_W      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W       = $clog2(LOG_DEPTH + 1);
   localparam int META_W      = HEAD_W + CNT_W;
   localparam int STAMP_DEPTH = NUM_SLOTS * (2 ** HEAD_W);

   // configuration
   logic [WINDOW_W-1:0] window_ff;
   logic [LIMIT_W-1:0]  max_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         max_req_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_WINDOW_MS:    window_ff  <= csr_wdata[WINDOW_W-1:0];
            REG_MAX_REQUESTS: max_req_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   logic [SLOT_W-1:0]  slot_ff;
   logic [STAMP_W-1:0] now_ff;
   logic               in_range_ff;
   logic [SLOT_W-1:0]  in_slot;
   logic               in_range;

   assign in_slot  = SLOT_W'(req_user_slot);
   assign in_range = (32'(req_user_slot) < NUM_SLOTS);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slot_ff     <= in_slot;
         now_ff      <= req_now_ms;
         in_range_ff <= in_range;
      end
   end

   // ring table: head and count per slot
   logic [META_W-1:0] meta_mem [NUM_SLOTS];
   logic [META_W-1:0] meta_rd_ff;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic              meta_we;
   logic [SLOT_W-1:0] meta_wa;
   logic [META_W-1:0] meta_wd;
   logic [HEAD_W-1:0] meta_head;
   logic [CNT_W-1:0]  meta_cnt;

   assign meta_head = meta_rd_ff[META_W-1:CNT_W];
   assign meta_cnt  = meta_rd_ff[CNT_W-1:0];
   assign clr_in    = cmd.clear ? clr_ff + 1'b1 : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else       clr_ff <= clr_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      meta_rd_ff <= meta_mem[in_slot];
   end

   // working ring position
   logic [HEAD_W-1:0] head_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [HEAD_W-1:0] head_inc;

   assign head_inc = (head_ff == HEAD_W'(LOG_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         head_ff <= meta_head;
         cnt_ff  <= meta_cnt;
      end else if (cmd.pop) begin
         head_ff <= head_inc;
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   // stamp memory, one ring of 2**HEAD_W entries per slot
   logic [STAMP_W-1:0]       stamp_mem [STAMP_DEPTH];
   logic [STAMP_W-1:0]       stamp_rd_ff;
   logic [HEAD_W-1:0]        rd_pos;
   logic [HEAD_W-1:0]        tail;
   logic [31:0]              tail_sum;
   logic                     stamp_we;

   // read one ahead, so the stamp behind the head is ready as a pop moves on
   assign rd_pos = cmd.load ? meta_head : head_inc;

   always_ff @(posedge clock) begin
      if (stamp_we) stamp_mem[{slot_ff, tail}] <= now_ff;
      stamp_rd_ff <= stamp_mem[{slot_ff, rd_pos}];
   end

   // window compare: a stamp ahead of now has age zero
   logic [STAMP_W:0]   diff;
   logic [STAMP_W-1:0] age;

   assign diff = {1'b0, now_ff} - {1'b0, stamp_rd_ff};
   assign age  = diff[STAMP_W] ? '0 : diff[STAMP_W-1:0];

   // decision
   logic [CNT_W-1:0] limit;
   logic             ok;
   logic [CNT_W-1:0] cnt_new;

   assign limit    = (32'(max_req_ff) > LOG_DEPTH) ? CNT_W'(LOG_DEPTH) : CNT_W'(max_req_ff);
   assign ok       = in_range_ff && (cnt_ff < limit);
   assign cnt_new  = ok ? cnt_ff + 1'b1 : cnt_ff;
   assign tail_sum = 32'(head_ff) + 32'(cnt_ff);
   assign tail     = (tail_sum >= LOG_DEPTH) ? HEAD_W'(tail_sum - LOG_DEPTH)
                                              : HEAD_W'(tail_sum);
   assign stamp_we = cmd.decide && ok;

   assign meta_we = cmd.clear || (cmd.decide && in_range_ff);
   assign meta_wa = cmd.clear ? clr_ff : slot_ff;
   assign meta_wd = cmd.clear ? '0 : {head_ff, cnt_new};

   // result word
   logic              allowed_ff;
   logic [LIVE_W-1:0] live_ff;

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         allowed_ff <= ok;
         live_ff    <= in_range_ff ? LIVE_W'(cnt_new) : '0;
      end
   end

   assign rsp_allowed    = allowed_ff;
   assign rsp_live_count = live_ff;

   assign sts.slot_ok    = in_range;
   assign sts.clear_done = (clr_ff == SLOT_W'(NUM_SLOTS - 1));
   assign sts.cnt_zero   = (cnt_ff == '0);
   assign sts.expired    = (age > {{(STAMP_W - WINDOW_W){1'b0}}, window_ff});

endmodule

// ===== rtl/sliding_window_log_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_log_rate_limiter
// per-slot log of accepted request times; refuses a request once the slot
// already holds the limit of stamps inside the window
// ----------------------------------------------------------------------------
// channel   dir  handshake    word
// req_chan  in   valid/ready  user_slot, now_ms
// rsp_chan  out  valid/ready  allowed, live_count
// csr_*     in   csr_we       csr_index, csr_wdata (write only)
//
// a request runs accept, ring load, expiry loop, decision; expired stamps
// (0..LOG_DEPTH) pop one per cycle through the single stamp memory read
// port; a slot outside the table skips to the decision. one request is in
// flight at a time. after reset the ring table is cleared slot by slot,
// req_chan not ready meanwhile. a result waits in the output register; the
// next request is taken but holds at its decision until that word is taken.
// ----------------------------------------------------------------------------
module sliding_window_log_rate_limiter import swlrl_pkg::*; #(
   parameter int NUM_SLOTS = 64,
   parameter int LOG_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   swlrl_req_if.sink             req_chan,
   swlrl_rsp_if.source           rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   swlrl_cmd_type cmd;
   swlrl_sts_type sts;

   swlrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   swlrl_dp #(
      .NUM_SLOTS (NUM_SLOTS),
      .LOG_DEPTH (LOG_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_user_slot  (req_chan.user_slot),
      .req_now_ms     (req_chan.now_ms),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_allowed    (rsp_chan.allowed),
      .rsp_live_count (rsp_chan.live_count)
   );

endmodule

// ===== rtl/swlrl_checker.sv =====
// ----------------------------------------------------------------------------
// swlrl_checker
// port-level checks of the rate limiter, bound onto the top level
// ----------------------------------------------------------------------------
`include "sliding_window_log_rate_limiter_defines.svh"

module swlrl_checker import swlrl_pkg::*; #(
   parameter int LOG_DEPTH = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_allowed,
   input logic [LIVE_W-1:0] rsp_live_count
);

   // a word that is not taken stays up
   `SWLRL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // reset leaves no result and runs the table clear first
   `SWLRL_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_ready)

   // one request at a time: busy right after taking one
   `SWLRL_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // an allowed request always leaves its own stamp behind
   `SWLRL_ASSERT_IMP(a_allow_count, clock, reset,
      rsp_valid && rsp_allowed && (LOG_DEPTH < 32), rsp_live_count != '0)

endmodule

bind sliding_window_log_rate_limiter swlrl_checker #(
   .LOG_DEPTH (LOG_DEPTH)
) u_swlrl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_allowed    (rsp_chan.allowed),
   .rsp_live_count (rsp_chan.live_count)
);

// ===== tb/sliding_window_log_rate_limiter_test.sv =====
// ----------------------------------------------------------------------------
// sliding_window_log_rate_limiter_test
// self-checking bench: a scoreboard keeps its own per-slot stamp rings and
// predicts the allow/refuse verdict and live count of every request word,
// under directed corner cases and random bursts across several settings
// ----------------------------------------------------------------------------
module sliding_window_log_rate_limiter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import swlrl_pkg::*;

   localparam int NUM_SLOTS   = 64;
   localparam int LOG_DEPTH   = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int END_GUARD   = 40;
   localparam int MAX_REPORTS = 200;
   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

   typedef struct packed {
      logic              allowed;
      logic [LIVE_W-1:0] live_count;
   } verdict_type;

   class rate_limit_scoreboard;
      bit   [STAMP_W-1:0]  stamp_log [NUM_SLOTS][LOG_DEPTH];
      logic [3:0]          ring_head [NUM_SLOTS];
      logic [4:0]          ring_count [NUM_SLOTS];
      logic [WINDOW_W-1:0] window_ms;
      logic [LIMIT_W-1:0]  max_requests;
      verdict_type         pending_verdicts [$];
      int                  errors;
      int                  reports;
      int                  requests_seen;
      int                  allowed_seen;

      function new();
         foreach (ring_head[i]) begin
            ring_head[i]  = '0;
            ring_count[i] = '0;
         end
         window_ms     = WINDOW_RESET;
         max_requests  = LIMIT_RESET;
         errors        = 0;
         reports       = 0;
         requests_seen = 0;
         allowed_seen  = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_WINDOW_MS:    window_ms    = data[WINDOW_W-1:0];
            REG_MAX_REQUESTS: max_requests = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      // expire old stamps, then append or refuse
      function void note_request(logic [SLOT_IN_W-1:0] slot, logic [STAMP_W-1:0] now);
         logic [3:0]         head;
         logic [3:0]         tail;
         logic [4:0]         count;
         logic [4:0]         eff_limit;
         logic [STAMP_W-1:0] age;
         logic               done;
         verdict_type        v;
         head  = ring_head[slot];
         count = ring_count[slot];
         done  = 1'b0;
         while (count != 0 && !done) begin
            // a stamp ahead of now counts as age zero
            age = (now >= stamp_log[slot][head]) ? now - stamp_log[slot][head] : '0;
            if (age > STAMP_W'(window_ms)) begin
               head  = head + 4'd1;
               count = count - 5'd1;
            end else begin
               done = 1'b1;
            end
         end
         eff_limit = (max_requests > 5'(LOG_DEPTH)) ? 5'(LOG_DEPTH) : max_requests;
         v.allowed = (count < eff_limit);
         if (v.allowed) begin
            tail = head + count[3:0];
            stamp_log[slot][tail] = now;
            count = count + 5'd1;
            allowed_seen++;
         end
         ring_head[slot]  = head;
         ring_count[slot] = count;
         v.live_count = count;
         pending_verdicts.push_back(v);
         requests_seen++;
      endfunction

      function void check_result(logic allowed, logic [LIVE_W-1:0] live_count);
         verdict_type exp_v;
         if (pending_verdicts.size() == 0) begin
            errors++;
            $display("%0t: response word with no request pending: allowed %0b live_count %0d",
                     $time, allowed, live_count);
            return;
         end
         exp_v = pending_verdicts.pop_front();
         if (allowed !== exp_v.allowed || live_count !== exp_v.live_count) begin
            errors++;
            reports++;
            if (reports <= MAX_REPORTS)
               $display({"%0t: mismatch: expected allowed %0b live_count %0d, ",
                         "got allowed %0b live_count %0d"},
                        $time, exp_v.allowed, exp_v.live_count, allowed, live_count);
            else if (reports == MAX_REPORTS + 1)
               $display("%0t: further mismatches counted but not shown", $time);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   swlrl_req_if req_chan ();
   swlrl_rsp_if rsp_chan ();

   sliding_window_log_rate_limiter uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rate_limit_scoreboard sb = new();

   int                 req_idle_pct = 0;
   int                 rsp_idle_pct = 0;
   bit                 long_hold_req = 1'b0;
   int                 settings_applied = 0;
   int                 cycle_count = 0;
   logic [STAMP_W-1:0] slot_clock [NUM_SLOTS];

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // both channels are sampled at the edge, before any drive of this step lands
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         sb.note_request(req_chan.user_slot, req_chan.now_ms);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result(rsp_chan.allowed, rsp_chan.live_count);
   end

   // response side: random stalls plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic send_request(input logic [SLOT_IN_W-1:0] slot, input logic [STAMP_W-1:0] now);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.user_slot <= slot;
      req_chan.now_ms    <= now;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      // wait for an edge so the last accepted word is booked before the count is read
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [WINDOW_W-1:0] win, input logic [LIMIT_W-1:0] lim);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= REG_WINDOW_MS;
      csr_wdata <= CSR_DATA_W'(win);
      sb.set_register(REG_WINDOW_MS, CSR_DATA_W'(win));
      @(posedge clock);
      csr_index <= REG_MAX_REQUESTS;
      csr_wdata <= CSR_DATA_W'(lim);
      sb.set_register(REG_MAX_REQUESTS, CSR_DATA_W'(lim));
      @(posedge clock);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // mostly small steps inside the window, some jumps past it, a few steps back
   function automatic logic [STAMP_W-1:0] next_time(input logic [STAMP_W-1:0] t,
                                                     input logic [WINDOW_W-1:0] win);
      logic [63:0] span;
      logic [63:0] r;
      int          pick;
      span = {32'd0, win} + 64'd1;
      r    = 64'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 20)
         return t;
      else if (pick < 75)
         return t + STAMP_W'(r % (span / 4 + 64'd1));
      else if (pick < 94)
         return t + STAMP_W'(span + r % span);
      else
         return t - STAMP_W'($urandom_range(1, 40));
   endfunction

   task automatic random_phase(input logic [WINDOW_W-1:0] win, input logic [LIMIT_W-1:0] lim,
                               input int n_items, input int drain_at, input int hold_at);
      logic [SLOT_IN_W-1:0] hot [4];
      logic [SLOT_IN_W-1:0] slot;
      logic [STAMP_W-1:0]   base;
      apply_settings(win, lim);
      base = STAMP_W'({$urandom, $urandom});
      foreach (slot_clock[i]) slot_clock[i] = base;
      foreach (hot[i]) hot[i] = SLOT_IN_W'($urandom_range(0, NUM_SLOTS - 1));
      for (int i = 0; i < n_items; i++) begin
         if (i == drain_at) drain_results();
         if (i == hold_at) long_hold_req = 1'b1;
         // a few busy slots so rings fill and expire
         if ($urandom_range(0, 99) < 80)
            slot = hot[$urandom_range(0, 3)];
         else
            slot = SLOT_IN_W'($urandom);
         slot_clock[slot] = next_time(slot_clock[slot], win);
         send_request(slot, slot_clock[slot]);
      end
   endtask

   task automatic run_directed();
      // reset settings: window edge is inclusive
      send_request(6'd5, 48'd0);
      send_request(6'd5, 48'd60000);
      send_request(6'd5, 48'd60001);
      apply_settings(32'd10, 5'd2);
      send_request(6'd0, 48'd0);
      send_request(6'd0, 48'd5);
      send_request(6'd0, 48'd10);
      send_request(6'd0, 48'd11);
      // time going backwards keeps the head stamp
      send_request(6'd0, 48'd3);
      send_request(6'd63, STAMP_MAX);
      send_request(6'd63, STAMP_MAX);
      send_request(6'd63, STAMP_MAX);
      // limit of zero refuses but still expires
      apply_settings(32'd10, 5'd0);
      send_request(6'd0, 48'd100);
      send_request(6'd1, 48'd0);
      // zero window with a limit above ring depth
      apply_settings(32'd0, 5'd31);
      send_request(6'd2, 48'd7);
      send_request(6'd2, 48'd7);
      send_request(6'd2, 48'd8);
      apply_settings(32'hFFFF_FFFF, 5'd1);
      send_request(6'd3, 48'd0);
      send_request(6'd3, 48'h0000_FFFF_FFFF);
      send_request(6'd3, 48'h0001_0000_0000);
      send_request(6'd3, STAMP_MAX);
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.user_slot = '0;
      req_chan.now_ms    = '0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 29;
      rsp_idle_pct = 49;
      run_directed();
      random_phase(32'd50, 5'd4, 205, -1, -1);
      random_phase(32'd0, 5'd1, 205, -1, -1);
      req_idle_pct = 49;
      rsp_idle_pct = 29;
      random_phase(32'd1000, 5'd31, 205, 100, -1);
      random_phase(32'hFFFF_FFFF, 5'd16, 205, -1, -1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_phase(WINDOW_W'($urandom_range(1, 500)), 5'd0, 205, -1, 60);
      random_phase(32'd60000, 5'd10, 205, -1, -1);

      drain_results();
      repeat (END_GUARD) @(posedge clock);

      $display("checked %0d request words: %0d allowed, %0d refused",
               sb.requests_seen, sb.allowed_seen, sb.requests_seen - sb.allowed_seen);
      $display("across %0d window/limit settings including zero and full-scale values",
               settings_applied);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d verdicts never answered", sb.errors, sb.pending());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/swlrl_pkg.sv
rtl/swlrl_if.sv
rtl/swlrl_ctrl.sv
rtl/swlrl_dp.sv
rtl/sliding_window_log_rate_limiter.sv
rtl/swlrl_checker.sv
tb/sliding_window_log_rate_limiter_test.sv
